/* rtl/core/v3a_pkg.sv */
package v3a_pkg;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_MUL       = 4'd2,
    OP_DIV       = 4'd3,
    OP_SCALE     = 4'd4,
    OP_DIVSCALAR = 4'd5,
    OP_NEGATE    = 4'd6,
    OP_DOT       = 4'd7,
    OP_CROSS     = 4'd8,
    OP_MAGNITUDE = 4'd9,
    OP_NORMALIZE = 4'd10,
    OP_LERP      = 4'd11
  } op_t;

  localparam int          WEIGHT_BITS = 16;
  localparam logic [16:0] WEIGHT_ONE  = 17'd65536;
  localparam int          SQRT_STEPS  = 32;
  localparam int          SAT_W       = 72;

  typedef logic signed [31:0]      word_t;
  typedef word_t [2:0]             vec_t;
  typedef logic signed [32:0]      opnd_t;
  typedef opnd_t [2:0]             ovec_t;
  typedef logic signed [65:0]      prod_t;
  typedef prod_t [2:0]             pvec_t;
  typedef logic signed [66:0]      lsum_t;
  typedef lsum_t [2:0]             lvec_t;
  typedef logic signed [67:0]      dsum_t;
  typedef logic signed [SAT_W-1:0] wide_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    op_t   op;
    vec_t  r;
    word_t s;
    vec_t  a;
    vec_t  b;
    word_t k;
  } ride_t;

  typedef struct packed {
    ride_t       ride;
    logic [63:0] n;
    logic [63:0] root;
  } sqrt_t;

  typedef struct packed {
    op_t        op;
    vec_t       r;
    word_t      s;
    logic       fault;
    logic       zero_q;
    logic [2:0] neg;
  } dvside_t;

  typedef struct packed {
    vec_t  r;
    word_t s;
    logic  fault;
  } res_t;

  function automatic word_t sat32(input wide_t v);
    if ((&v[SAT_W-1:31]) || (~|v[SAT_W-1:31])) begin
      return v[31:0];
    end
    return v[SAT_W-1] ? WORD_MIN : WORD_MAX;
  endfunction

endpackage

/* rtl/core/v3a_in_if.sv */
interface v3a_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         req_type;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar_in;
  logic [16:0]        blend_weight;

  modport source (
    output valid, req_type, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, blend_weight,
    input  ready
  );
  modport sink (
    input  valid, req_type, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, blend_weight,
    output ready
  );
endinterface

/* rtl/core/v3a_out_if.sv */
interface v3a_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] scalar_out;
  logic               fault;

  modport source (
    output valid, r_x, r_y, r_z, scalar_out, fault,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, scalar_out, fault,
    output ready
  );
endinterface

/* rtl/core/vec3_arith_unit.sv */
// Three-component signed fixed-point vector ALU.
// The input channel in_ch carries an opcode, vectors A and B, a scalar and a
// lerp weight; the output channel out_ch returns one result per transfer:
// a vector, a scalar for dot and magnitude, and a fault flag for a zero divisor.
// Both channels use valid/ready; a transfer happens when both are high.
// The block is a fixed pipeline: operand select, multiply, lane combine,
// reduction, 32 square-root steps, divider setup, one restoring-division
// step per quotient bit (32 + FRAC_BITS steps), then the output register.
// Throughput is one transfer per cycle, except while an output stall holds in_ch.ready low.
// A skid register behind the output register lets the pipeline advance once
// more while a result waits; after that, while out_ch.ready stays low, the
// whole pipeline holds and in_ch.ready is low. Nothing is dropped or repeated.
// Synchronous reset clears every valid bit, so the block comes up empty and
// ready; results in flight at reset are discarded.
module vec3_arith_unit
  import v3a_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  v3a_in_if.sink    in_ch,
  v3a_out_if.source out_ch
);

  localparam int NW = 32 + FRAC_BITS;

  logic en;
  logic take;

  op_t         in_op;
  logic [16:0] w_cl;
  logic [16:0] w_cmp;
  vec_t        a_in;
  vec_t        b_in;
  vec_t        simp_nxt;
  ovec_t       x0_nxt, y0_nxt, x1_nxt, y1_nxt;
  ride_t       s1_ride_nxt;

  logic  s1_v_r;
  ride_t s1_ride_r;
  ovec_t s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r;

  logic  s2_v_r;
  ride_t s2_ride_r;
  pvec_t s2_m0_r, s2_m1_r;

  logic  s3_v_r;
  ride_t s3_ride_r;
  lvec_t s3_t_r;
  lvec_t s3_t_nxt;

  dsum_t s4_tot;
  vec_t  s4_lane;
  sqrt_t s4_nxt;

  logic        sqv_r    [SQRT_STEPS+1];
  sqrt_t       sqs_r    [SQRT_STEPS+1];
  sqrt_t       sqs_nxt  [SQRT_STEPS];
  logic [64:0] sq_trial [SQRT_STEPS];

  logic [31:0] dv0_mag;
  vec_t        dv0_dsel;
  dvside_t     dv0_side;
  logic [31:0] dv0_den [3];
  logic [NW-1:0] dv0_nq [3];

  logic          dvv_r      [NW+1];
  dvside_t       dvs_r      [NW+1];
  logic [31:0]   dv_rem_r   [NW+1][3];
  logic [31:0]   dv_den_r   [NW+1][3];
  logic [NW-1:0] dv_nq_r    [NW+1][3];
  logic [32:0]   dv_rem2    [NW][3];
  logic          dv_ge      [NW][3];
  logic [31:0]   dv_rem_nxt [NW][3];

  wide_t fin_q [3];
  res_t  fin;

  logic out_v_r;
  logic skid_v_r;
  res_t out_r;
  res_t skid_r;

  assign take        = out_v_r && out_ch.ready;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  assign in_op = op_t'(in_ch.req_type);
  assign a_in  = {in_ch.a_z, in_ch.a_y, in_ch.a_x};
  assign b_in  = {in_ch.b_z, in_ch.b_y, in_ch.b_x};
  assign w_cl  = (in_ch.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_ch.blend_weight;
  assign w_cmp = WEIGHT_ONE - w_cl;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x0_nxt[i]   = opnd_t'(a_in[i]);
      y0_nxt[i]   = opnd_t'(b_in[i]);
      x1_nxt[i]   = '0;
      y1_nxt[i]   = '0;
      simp_nxt[i] = '0;
      case (in_op)
        OP_ADD:    simp_nxt[i] = sat32(wide_t'(opnd_t'(a_in[i]) + opnd_t'(b_in[i])));
        OP_SUB:    simp_nxt[i] = sat32(wide_t'(opnd_t'(a_in[i]) - opnd_t'(b_in[i])));
        OP_NEGATE: simp_nxt[i] = sat32(wide_t'(-opnd_t'(a_in[i])));
        OP_SCALE:  y0_nxt[i] = opnd_t'(in_ch.scalar_in);
        OP_MAGNITUDE, OP_NORMALIZE: y0_nxt[i] = opnd_t'(a_in[i]);
        OP_LERP: begin
          y0_nxt[i] = {16'b0, w_cmp};
          x1_nxt[i] = opnd_t'(b_in[i]);
          y1_nxt[i] = {16'b0, w_cl};
        end
        default: begin
        end
      endcase
    end
    if (in_op == OP_CROSS) begin
      x0_nxt[0] = opnd_t'(a_in[1]);
      y0_nxt[0] = opnd_t'(b_in[2]);
      x1_nxt[0] = opnd_t'(a_in[2]);
      y1_nxt[0] = opnd_t'(b_in[1]);
      x0_nxt[1] = opnd_t'(b_in[0]);
      y0_nxt[1] = opnd_t'(a_in[2]);
      x1_nxt[1] = opnd_t'(a_in[0]);
      y1_nxt[1] = opnd_t'(b_in[2]);
      x0_nxt[2] = opnd_t'(a_in[0]);
      y0_nxt[2] = opnd_t'(b_in[1]);
      x1_nxt[2] = opnd_t'(b_in[0]);
      y1_nxt[2] = opnd_t'(a_in[1]);
    end
    s1_ride_nxt.op = in_op;
    s1_ride_nxt.r  = simp_nxt;
    s1_ride_nxt.s  = '0;
    s1_ride_nxt.a  = a_in;
    s1_ride_nxt.b  = b_in;
    s1_ride_nxt.k  = in_ch.scalar_in;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (s2_ride_r.op)
        OP_CROSS: s3_t_nxt[i] = lsum_t'(s2_m0_r[i]) - lsum_t'(s2_m1_r[i]);
        OP_LERP:  s3_t_nxt[i] = lsum_t'(s2_m0_r[i]) + lsum_t'(s2_m1_r[i]);
        default:  s3_t_nxt[i] = lsum_t'(s2_m0_r[i]);
      endcase
    end
  end

  always_comb begin
    s4_tot = dsum_t'(s3_t_r[0]) + dsum_t'(s3_t_r[1]) + dsum_t'(s3_t_r[2]);
    s4_nxt.ride   = s3_ride_r;
    s4_nxt.ride.s = '0;
    s4_nxt.n      = s4_tot[63:0];
    s4_nxt.root   = '0;
    for (int i = 0; i < 3; i++) begin
      if (s3_ride_r.op == OP_LERP) begin
        s4_lane[i] = sat32(wide_t'(s3_t_r[i] >>> WEIGHT_BITS));
      end else begin
        s4_lane[i] = sat32(wide_t'(s3_t_r[i] >>> FRAC_BITS));
      end
      case (s3_ride_r.op)
        OP_ADD, OP_SUB, OP_NEGATE:        s4_nxt.ride.r[i] = s3_ride_r.r[i];
        OP_MUL, OP_SCALE, OP_CROSS, OP_LERP: s4_nxt.ride.r[i] = s4_lane[i];
        default:                          s4_nxt.ride.r[i] = '0;
      endcase
    end
    if (s3_ride_r.op == OP_DOT) begin
      s4_nxt.ride.s = sat32(wide_t'(s4_tot >>> FRAC_BITS));
    end
  end

  always_comb begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      sqs_nxt[j]  = sqs_r[j];
      sq_trial[j] = 65'(sqs_r[j].root) + (65'(1) << (62 - 2 * j));
      if (65'(sqs_r[j].n) >= sq_trial[j]) begin
        sqs_nxt[j].n    = sqs_r[j].n - sq_trial[j][63:0];
        sqs_nxt[j].root = (sqs_r[j].root >> 1) + (64'(1) << (62 - 2 * j));
      end else begin
        sqs_nxt[j].root = sqs_r[j].root >> 1;
      end
    end
  end

  always_comb begin
    dv0_mag          = sqs_r[SQRT_STEPS].root[31:0];
    dv0_side.op      = sqs_r[SQRT_STEPS].ride.op;
    dv0_side.r       = sqs_r[SQRT_STEPS].ride.r;
    dv0_side.s       = sqs_r[SQRT_STEPS].ride.s;
    dv0_side.fault   = 1'b0;
    dv0_side.zero_q  = 1'b0;
    dv0_side.neg     = '0;
    case (dv0_side.op)
      OP_DIV: begin
        dv0_side.fault = (sqs_r[SQRT_STEPS].ride.b[0] == '0) ||
                         (sqs_r[SQRT_STEPS].ride.b[1] == '0) ||
                         (sqs_r[SQRT_STEPS].ride.b[2] == '0);
      end
      OP_DIVSCALAR: dv0_side.fault = (sqs_r[SQRT_STEPS].ride.k == '0);
      OP_MAGNITUDE: dv0_side.s = dv0_mag[31] ? WORD_MAX : dv0_mag;
      default: begin
      end
    endcase
    dv0_side.zero_q = dv0_side.fault ||
                      ((dv0_side.op == OP_NORMALIZE) && (dv0_mag == '0));
    for (int i = 0; i < 3; i++) begin
      case (dv0_side.op)
        OP_DIV:       dv0_dsel[i] = sqs_r[SQRT_STEPS].ride.b[i];
        OP_DIVSCALAR: dv0_dsel[i] = sqs_r[SQRT_STEPS].ride.k;
        default:      dv0_dsel[i] = '0;
      endcase
      if (dv0_side.op == OP_NORMALIZE) begin
        dv0_den[i] = dv0_mag;
      end else begin
        dv0_den[i] = dv0_dsel[i][31] ? 32'(-dv0_dsel[i]) : 32'(dv0_dsel[i]);
      end
      dv0_side.neg[i] = sqs_r[SQRT_STEPS].ride.a[i][31] ^
                        ((dv0_side.op != OP_NORMALIZE) && dv0_dsel[i][31]);
      dv0_nq[i] = {(sqs_r[SQRT_STEPS].ride.a[i][31] ? 32'(-sqs_r[SQRT_STEPS].ride.a[i])
                                                     : 32'(sqs_r[SQRT_STEPS].ride.a[i])),
                   FRAC_BITS'(0)};
    end
  end

  always_comb begin
    for (int j = 0; j < NW; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem2[j][i]    = {dv_rem_r[j][i], dv_nq_r[j][i][NW-1]};
        dv_ge[j][i]      = dv_rem2[j][i] >= {1'b0, dv_den_r[j][i]};
        dv_rem_nxt[j][i] = dv_ge[j][i] ? 32'(dv_rem2[j][i] - {1'b0, dv_den_r[j][i]})
                                       : dv_rem2[j][i][31:0];
      end
    end
  end

  always_comb begin
    fin.s     = dvs_r[NW].s;
    fin.fault = dvs_r[NW].fault;
    for (int i = 0; i < 3; i++) begin
      fin_q[i] = dvs_r[NW].neg[i] ? -wide_t'(dv_nq_r[NW][i]) : wide_t'(dv_nq_r[NW][i]);
      case (dvs_r[NW].op)
        OP_DIV, OP_DIVSCALAR, OP_NORMALIZE: begin
          fin.r[i] = dvs_r[NW].zero_q ? '0 : sat32(fin_q[i]);
        end
        default: fin.r[i] = dvs_r[NW].r[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      for (int j = 0; j <= SQRT_STEPS; j++) begin
        sqv_r[j] <= 1'b0;
      end
      for (int j = 0; j <= NW; j++) begin
        dvv_r[j] <= 1'b0;
      end
    end else if (en) begin
      s1_v_r   <= in_ch.valid;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
      sqv_r[0] <= s3_v_r;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        sqv_r[j+1] <= sqv_r[j];
      end
      dvv_r[0] <= sqv_r[SQRT_STEPS];
      for (int j = 0; j < NW; j++) begin
        dvv_r[j+1] <= dvv_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ride_r <= s1_ride_nxt;
      s1_x0_r   <= x0_nxt;
      s1_y0_r   <= y0_nxt;
      s1_x1_r   <= x1_nxt;
      s1_y1_r   <= y1_nxt;
      s2_ride_r <= s1_ride_r;
      for (int i = 0; i < 3; i++) begin
        s2_m0_r[i] <= s1_x0_r[i] * s1_y0_r[i];
        s2_m1_r[i] <= s1_x1_r[i] * s1_y1_r[i];
      end
      s3_ride_r <= s2_ride_r;
      s3_t_r    <= s3_t_nxt;
      sqs_r[0]  <= s4_nxt;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        sqs_r[j+1] <= sqs_nxt[j];
      end
      dvs_r[0] <= dv0_side;
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= '0;
        dv_den_r[0][i] <= dv0_den[i];
        dv_nq_r[0][i]  <= dv0_nq[i];
      end
      for (int j = 0; j < NW; j++) begin
        dvs_r[j+1] <= dvs_r[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j+1][i] <= dv_rem_nxt[j][i];
          dv_den_r[j+1][i] <= dv_den_r[j][i];
          dv_nq_r[j+1][i]  <= {dv_nq_r[j][i][NW-2:0], dv_ge[j][i]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en) begin
      if (dvv_r[NW]) begin
        if (!out_v_r || take) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (take) begin
        out_v_r <= 1'b0;
      end
    end else if (take) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dvv_r[NW] && (!out_v_r || take)) begin
        out_r <= fin;
      end else if (dvv_r[NW]) begin
        skid_r <= fin;
      end
    end else if (take) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.r_x        = out_r.r[0];
  assign out_ch.r_y        = out_r.r[1];
  assign out_ch.r_z        = out_r.r[2];
  assign out_ch.scalar_out = out_r.s;
  assign out_ch.fault      = out_r.fault;

endmodule

/* sim/vec3_scoreboard.sv */
module vec3_scoreboard
  import v3a_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  v3a_in_if    in_ch,
  v3a_out_if   out_ch,
  output int   errors,
  output int   in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  res_t awaited[$];

  function automatic word_t clamp(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return WORD_MAX;
    if (v < -68'sd2147483648) return WORD_MIN;
    return v[31:0];
  endfunction

  function automatic word_t fix_div(input longint n, input longint d);
    longint q;
    q = (n * (longint'(1) <<< FRAC_BITS)) / d;
    return clamp(68'(q));
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic res_t compute_vec3(input logic [3:0] op, input vec_t av, input vec_t bv,
                                        input word_t kv, input logic [16:0] wv);
    res_t r;
    longint a[3], b[3], k, w, mag;
    logic signed [67:0] acc;
    longint unsigned sq;
    r = '0;
    k = kv;
    w = (wv > WEIGHT_ONE) ? 65536 : longint'(wv);
    for (int i = 0; i < 3; i++) begin
      a[i] = av[i];
      b[i] = bv[i];
    end
    case (op)
      OP_ADD: for (int i = 0; i < 3; i++) r.r[i] = clamp(68'(a[i] + b[i]));
      OP_SUB: for (int i = 0; i < 3; i++) r.r[i] = clamp(68'(a[i] - b[i]));
      OP_MUL: for (int i = 0; i < 3; i++) r.r[i] = clamp(68'(a[i] * b[i]) >>> FRAC_BITS);
      OP_DIV: begin
        if (b[0] == 0 || b[1] == 0 || b[2] == 0) r.fault = 1'b1;
        else for (int i = 0; i < 3; i++) r.r[i] = fix_div(a[i], b[i]);
      end
      OP_SCALE: for (int i = 0; i < 3; i++) r.r[i] = clamp(68'(a[i] * k) >>> FRAC_BITS);
      OP_DIVSCALAR: begin
        if (k == 0) r.fault = 1'b1;
        else for (int i = 0; i < 3; i++) r.r[i] = fix_div(a[i], k);
      end
      OP_NEGATE: for (int i = 0; i < 3; i++) r.r[i] = clamp(-68'(a[i]));
      OP_DOT: begin
        acc = 68'(a[0] * b[0]) + 68'(a[1] * b[1]) + 68'(a[2] * b[2]);
        r.s = clamp(acc >>> FRAC_BITS);
      end
      OP_CROSS: begin
        r.r[0] = clamp((68'(a[1] * b[2]) - 68'(a[2] * b[1])) >>> FRAC_BITS);
        r.r[1] = clamp((68'(b[0] * a[2]) - 68'(a[0] * b[2])) >>> FRAC_BITS);
        r.r[2] = clamp((68'(a[0] * b[1]) - 68'(b[0] * a[1])) >>> FRAC_BITS);
      end
      OP_MAGNITUDE, OP_NORMALIZE: begin
        sq = longint'(a[0] * a[0]) + longint'(a[1] * a[1]) + longint'(a[2] * a[2]);
        mag = longint'(root64(sq));
        if (op == OP_MAGNITUDE) r.s = clamp(68'(mag));
        else if (mag != 0) for (int i = 0; i < 3; i++) r.r[i] = fix_div(a[i], mag);
      end
      OP_LERP: begin
        for (int i = 0; i < 3; i++)
          r.r[i] = clamp(68'(a[i] * (65536 - w) + b[i] * w) >>> WEIGHT_BITS);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want, got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        awaited.push_back(compute_vec3(in_ch.req_type, {in_ch.a_z, in_ch.a_y, in_ch.a_x},
                                       {in_ch.b_z, in_ch.b_y, in_ch.b_x},
                                       in_ch.scalar_in, in_ch.blend_weight));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.r = {out_ch.r_z, out_ch.r_y, out_ch.r_x};
        got.s = out_ch.scalar_out;
        got.fault = out_ch.fault;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result transfer r=%h s=%h fault=%b",
                   $time, got.r, got.s, got.fault);
          errors++;
        end else begin
          want = awaited.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got.r[i] !== want.r[i]) begin
              $display("%0t: r[%0d] expected %h actual %h", $time, i, want.r[i], got.r[i]);
              errors++;
            end
          end
          if (got.s !== want.s) begin
            $display("%0t: scalar_out expected %h actual %h", $time, want.s, got.s);
            errors++;
          end
          if (got.fault !== want.fault) begin
            $display("%0t: fault expected %b actual %b", $time, want.fault, got.fault);
            errors++;
          end
        end
      end
    end
    in_flight = awaited.size();
  end
endmodule

/* sim/tb.sv */
module tb
  import v3a_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int   errors;
  int   in_flight;
  int   cycles;
  int   burst_left;
  int   stall_mode;
  int   mode_left;

  v3a_in_if  in_ch();
  v3a_out_if out_ch();

  vec3_arith_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vec3_scoreboard #(.FRAC_BITS(16)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .in_flight (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(5, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 1);
      2: out_ch.ready <= ($urandom_range(0, 9) == 0);
      default: out_ch.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  function automatic vec_t mk(input word_t x, input word_t y, input word_t z);
    return {z, y, x};
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 11))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return ($urandom_range(0, 1) == 1) ? 32'sh0001_0000 : -32'sh0001_0000;
      4, 5: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      6: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WEIGHT_ONE;
      2: return $urandom_range(0, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic issue(input logic [3:0] op, input vec_t a, input vec_t b,
                       input word_t k, input logic [16:0] w);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= op;
    in_ch.a_x          <= a[0];
    in_ch.a_y          <= a[1];
    in_ch.a_z          <= a[2];
    in_ch.b_x          <= b[0];
    in_ch.b_y          <= b[1];
    in_ch.b_z          <= b[2];
    in_ch.scalar_in    <= k;
    in_ch.blend_weight <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 150) : $urandom_range(1, 20);
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    vec_t one, big, tiny;
    logic [3:0] op;
    int settle;
    rst_n              = 1'b0;
    burst_left         = 5;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = '0;
    in_ch.a_x          = '0;
    in_ch.a_y          = '0;
    in_ch.a_z          = '0;
    in_ch.b_x          = '0;
    in_ch.b_y          = '0;
    in_ch.b_z          = '0;
    in_ch.scalar_in    = '0;
    in_ch.blend_weight = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    one  = mk(32'sh0001_0000, -32'sh0002_0000, 32'sh0003_8000);
    big  = mk(WORD_MAX, WORD_MIN, WORD_MAX);
    tiny = mk(32'sd1, -32'sd1, 32'sd0);
    issue(OP_ADD, big, big, '0, '0);
    issue(OP_SUB, mk(WORD_MIN, WORD_MAX, '0), big, '0, '0);
    issue(OP_MUL, big, big, '0, '0);
    issue(OP_MUL, tiny, mk(-32'sd1, -32'sd1, -32'sd1), '0, '0);
    issue(OP_DIV, one, mk(32'sh0001_0000, '0, 32'sd5), '0, '0);
    issue(OP_DIV, big, mk(-32'sd1, -32'sh0001_0000, 32'sd3), '0, '0);
    issue(OP_SCALE, big, '0, WORD_MIN, '0);
    issue(OP_SCALE, one, '0, -32'sh0000_8000, '0);
    issue(OP_DIVSCALAR, one, '0, '0, '0);
    issue(OP_DIVSCALAR, big, '0, 32'sd1, '0);
    issue(OP_NEGATE, big, '0, '0, '0);
    issue(OP_DOT, big, big, '0, '0);
    issue(OP_DOT, one, tiny, '0, '0);
    issue(OP_CROSS, big, mk(WORD_MIN, WORD_MAX, WORD_MIN), '0, '0);
    issue(OP_CROSS, one, mk(32'sh0004_0000, 32'sh0005_0000, -32'sh0006_0000), '0, '0);
    issue(OP_MAGNITUDE, big, '0, '0, '0);
    issue(OP_NORMALIZE, '0, big, WORD_MAX, '0);
    issue(OP_NORMALIZE, big, '0, '0, '0);
    issue(OP_NORMALIZE, tiny, '0, '0, '0);
    issue(OP_LERP, big, mk(WORD_MIN, WORD_MAX, WORD_MIN), '0, '0);
    issue(OP_LERP, big, mk(WORD_MIN, WORD_MAX, WORD_MIN), '0, WEIGHT_ONE);
    issue(OP_LERP, one, big, '0, 17'h1FFFF);
    issue(OP_LERP, one, tiny, '0, 17'd32768);
    for (int i = 12; i < 16; i++) issue(4'(i), big, big, WORD_MAX, WEIGHT_ONE);

    for (int n = 0; n < 500; n++) begin
      if ($urandom_range(0, 9) == 0) op = 4'($urandom_range(12, 15));
      else op = 4'($urandom_range(0, 11));
      issue(op, mk(pick_word(), pick_word(), pick_word()),
            mk(pick_word(), pick_word(), pick_word()), pick_word(), pick_weight());
    end
    in_ch.valid <= 1'b0;

    while (in_flight != 0) @(posedge clk);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
